FILE: hdl/ost_pkg.sv
// ----------------------------------------------------------------------------
// Ordered set table package
// Shared sizes, payload types, command codes and status codes.
// ----------------------------------------------------------------------------
package ost_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OUT_W    = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] position;
        t_status          status;
        logic [OUT_W-1:0] element_count;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_W-1:0] t;
        t = {{OUT_W{1'b0}}, v};
        return t[OUT_W-1:0];
    endfunction

endpackage

FILE: hdl/ost_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ost_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ost_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered set table sequencer
// Scans the entry RAM with one comparator, shifts entries down on a remove,
// and holds the element count and the result register.
// ----------------------------------------------------------------------------
module ost_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ost_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ost_pkg::t_out_item   o_out_item,
    output ost_pkg::t_ram_req    o_ram_req,
    input  logic [ost_pkg::KEY_W-1:0] i_rdata
);

    import ost_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    t_ram_req         ram_req;
    logic             match;
    logic [CNT_W-1:0] wr_idx;

    assign match  = r_rd_vld && (i_rdata == r_key);
    assign wr_idx = r_rd_idx - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_vld    = r_rd_vld;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        ram_req.we    = 1'b0;
        ram_req.waddr = wr_idx[ADDR_W-1:0];
        ram_req.wdata = i_rdata;
        ram_req.raddr = r_idx[ADDR_W-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_in_item.cmd;
                    n_key     = i_in_item.key;
                    n_idx     = '0;
                    n_rd_vld  = 1'b0;
                    n_hit     = 1'b0;
                    n_hit_idx = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_rd_idx;
                    n_rd_vld  = 1'b0;
                    if (r_cmd == CMD_REMOVE) begin
                        n_idx   = r_rd_idx + 1'b1;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (r_idx < r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    n_idx    = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = S_FIN;
                end else begin
                    n_rd_vld = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_rd_vld) begin
                    ram_req.we = 1'b1;
                end
                if (r_idx < r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                    n_out.found    = r_hit;
                    n_out.position = r_hit ? to_out(CNT_W'(r_hit_idx + 1'b1)) : '0;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (r_hit) begin
                                n_out.status = ST_DUP;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = r_count[ADDR_W-1:0];
                                ram_req.wdata = r_key;
                                n_count       = r_count + 1'b1;
                                n_out.status  = ST_OK;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_hit) begin
                                n_count      = r_count - 1'b1;
                                n_out.status = ST_OK;
                            end else begin
                                n_out.status = ST_ABSENT;
                            end
                        end
                        default: begin
                            n_out.status = r_hit ? ST_OK : ST_ABSENT;
                        end
                    endcase
                    n_out.element_count = to_out(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_rd_idx  <= n_rd_idx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_ram_req   = ram_req;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Element count exceeds the table capacity.");

    a_count_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_FIN |=> r_count == $past(r_count))
        else $error("Element count changed outside result completion.");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> (r_state == S_SHIFT || r_state == S_FIN))
        else $error("Entry write outside shift or completion.");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.we && r_state == S_SHIFT) |-> (r_rd_idx < r_count && r_rd_idx != '0))
        else $error("Shift writes outside the held entries.");

    a_result_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("Result raised outside completion.");

endmodule

FILE: hdl/ordered_set_table_core.sv
// ----------------------------------------------------------------------------
// Ordered set table core
// Table of unique signed 32-bit keys in insertion order with insert, lookup
// and remove commands.
// ----------------------------------------------------------------------------
// The input channel carries a command and a key; the output channel returns
// one result per input: found flag, 1-based position, status and the element
// count after the operation. Both channels use valid and ready, and a transfer
// happens when both are high at a rising clock edge.
// The block works on one item at a time. An item is scanned one entry per
// cycle through the read port of the entry RAM against a single comparator.
// A missed key is compared against every held entry before its result is
// raised, and a scan for a key that is found stops at that key.
// A successful remove stops the scan at the key and then moves each later
// entry down by one through the same RAM.
// The block is ready for the next transfer in the same cycle as the result is raised.
// The result sits in an output register, so a new item is taken while a
// result still waits; a stalled receiver holds only the completion of the
// following item. Reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
module ordered_set_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ost_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ost_pkg::t_out_item o_out_item
);

    import ost_pkg::*;

    t_ram_req         ram_req;
    logic [KEY_W-1:0] ram_rdata;

    ost_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_req   (ram_req),
        .i_rdata     (ram_rdata)
    );

    ost_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY),
        .AW    (ADDR_W)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Ordered set table core testbench
// Drives insert, lookup and remove commands through the valid/ready input
// channel and checks every result against a shadow copy of the key table.
// A directed pass covers the key extremes, duplicates, removes at the head,
// middle and tail, the spare command code and the empty table. Random traffic
// then cycles through fill, mixed and drain stretches, so the table reaches
// full, under three settings of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
    import ost_pkg::*;

    localparam logic [1:0]       CMD_SPARE    = 2'd3;
    localparam int               CYCLE_LIMIT  = 1_000_000;
    localparam int               DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int               BLOCK_LEN    = 44;
    localparam logic [KEY_W-1:0] KEY_MIN      = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX      = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO     = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONES     = 32'hFFFF_FFFF;

    class set_table_shadow;
        logic [KEY_W-1:0] keys [CAPACITY];
        int               held;
        t_out_item        pending_replies [$];
        int               mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int locate_key(logic [KEY_W-1:0] k);
            int i;
            for (i = 0; i < held; i++) begin
                if (keys[i] == k) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_command(t_in_item op);
            int        idx;
            int        i;
            t_status   st;
            t_out_item reply;
            idx            = locate_key(op.key);
            reply.found    = (idx >= 0);
            reply.position = (idx >= 0) ? OUT_W'(idx + 1) : '0;
            case (op.cmd)
                CMD_INSERT: begin
                    if (idx >= 0) begin
                        st = ST_DUP;
                    end else if (held >= CAPACITY) begin
                        st = ST_FULL;
                    end else begin
                        keys[held] = op.key;
                        held++;
                        st = ST_OK;
                    end
                end
                CMD_REMOVE: begin
                    if (idx >= 0) begin
                        for (i = idx; i + 1 < held; i++) begin
                            keys[i] = keys[i + 1];
                        end
                        held--;
                        st = ST_OK;
                    end else begin
                        st = ST_ABSENT;
                    end
                end
                default: begin
                    st = (idx >= 0) ? ST_OK : ST_ABSENT;
                end
            endcase
            reply.status        = st;
            reply.element_count = OUT_W'(held);
            pending_replies     = {pending_replies, reply};
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (pending_replies.size() == 0) begin
                $error("result with no transfer pending: found %0d, position %0d",
                       got.found, got.position);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.element_count !== want.element_count) begin
                $error("element_count: expected %0d, actual %0d",
                       want.element_count, got.element_count);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    int              send_idle = 0;
    int              recv_idle = 0;
    int              cycles    = 0;
    int              op_index  = 0;
    set_table_shadow shadow    = new();

    ordered_set_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ordered_set_table_core: mismatch");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            shadow.check_reply(o_out_item);
        end
    end

    task automatic send_op(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
        t_in_item op;
        op.cmd = cmd;
        op.key = key;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_command(op);
        @(negedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int held_bias);
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(0, 99);
        if (r < held_bias && shadow.held > 0) begin
            k = shadow.keys[$urandom_range(0, shadow.held - 1)];
        end else if (r < held_bias + 10) begin
            case ($urandom_range(0, 3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = KEY_ZERO;
                default: k = KEY_ONES;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic run_random(input int count);
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        int               r;
        int               j;
        for (j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            case ((op_index / BLOCK_LEN) % 4)
                0, 1: begin
                    cmd = (r < 90) ? CMD_INSERT : CMD_LOOKUP;
                    key = pick_key(10);
                end
                2: begin
                    cmd = 2'($urandom_range(0, 3));
                    key = pick_key(50);
                end
                default: begin
                    cmd = (r < 70) ? CMD_REMOVE : ((r < 85) ? CMD_LOOKUP : CMD_SPARE);
                    key = pick_key(80);
                end
            endcase
            send_op(cmd, key);
            op_index++;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        send_idle  = 32;
        recv_idle  = 46;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_op(CMD_INSERT, KEY_MIN);
        send_op(CMD_INSERT, KEY_MAX);
        send_op(CMD_INSERT, KEY_ZERO);
        send_op(CMD_INSERT, KEY_ONES);
        send_op(CMD_INSERT, 32'h0000_0001);
        send_op(CMD_INSERT, KEY_MAX);
        send_op(CMD_LOOKUP, KEY_MIN);
        send_op(CMD_LOOKUP, 32'h7FFF_FFFE);
        send_op(CMD_SPARE,  KEY_ONES);
        send_op(CMD_SPARE,  32'h0000_0002);
        send_op(CMD_REMOVE, KEY_ZERO);
        send_op(CMD_LOOKUP, KEY_ONES);
        send_op(CMD_LOOKUP, 32'h0000_0001);
        send_op(CMD_REMOVE, 32'h0000_0005);
        send_op(CMD_REMOVE, KEY_MIN);
        send_op(CMD_REMOVE, 32'h0000_0001);
        send_op(CMD_LOOKUP, KEY_ZERO);
        send_op(CMD_REMOVE, KEY_MAX);
        send_op(CMD_REMOVE, KEY_ONES);
        send_op(CMD_LOOKUP, KEY_ONES);
        send_op(CMD_REMOVE, KEY_ZERO);
        send_op(CMD_INSERT, 32'h5555_5555);
        send_op(CMD_INSERT, 32'hAAAA_AAAA);

        run_random(266);
        send_idle = 46;
        recv_idle = 32;
        run_random(267);
        send_idle = 0;
        recv_idle = 0;
        run_random(267);
        i_in_valid <= 1'b0;

        while (shadow.pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
            $display("ordered_set_table_core: match");
        end else begin
            $display("ordered_set_table_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: ordered_set_table_core.f
hdl/ost_pkg.sv
hdl/ost_ram.sv
hdl/ost_ctrl.sv
hdl/ordered_set_table_core.sv
test/testbench.sv
